// ----- src/sobth_pkg.sv -----
// sobth_pkg: shared constants, types and helpers for the sobel edge threshold block
// used by every module under src; depends on nothing
`timescale 1ns / 1ps

package sobth_pkg;

    // line store geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // field widths
    localparam int PIX_W      = 8;
    localparam int COLOR_W    = 3 * PIX_W;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH    = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT   = HEIGHT_W'(480);
    localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = THR_W'(120);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // output levels for interior pixels
    localparam logic [COLOR_W-1:0] COLOR_EDGE    = '0;
    localparam logic [COLOR_W-1:0] COLOR_NO_EDGE = '1;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0]  frame_width;
        logic [HEIGHT_W-1:0] frame_height;
        logic [THR_W-1:0]    edge_threshold;
    } t_cfg;

    // per-request position flags
    typedef struct packed {
        logic has_result;
        logic last;
        logic border;
    } t_pos_info;

    // x / 9 for x up to 1023, via (x + 1) * 455 / 4096
    function automatic logic [PIX_W-1:0] div9(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'({1'b0, x} + 11'd1) * 20'd455;
        return prod[19:12];
    endfunction

endpackage

// ----- src/sobel_edge_threshold_3x3.sv -----
// sobel_edge_threshold_3x3: top level of the streaming 3x3 sobel edge marker
// an accepted request is held in stage one, then reaches the result register;
// the result for a pixel is released by the request one line plus one pixel later
// one request per cycle unless stalled, set by the single read and write port line store
// reset: synchronous active-low; counters, window and registers clear, line stores do not
// depends on sobth_pkg, sobth_cfg_regs, sobth_line_buf, sobth_pos_ctrl, sobth_grad_core
`timescale 1ns / 1ps

module sobel_edge_threshold_3x3 import sobth_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input pixel stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [COLOR_W-1:0]    s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  logic                  s_axis_tuser,  // flush
    // result pixel stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [COLOR_W-1:0]    m_axis_tdata,  // result_red, result_green, result_blue
    output logic                  m_axis_tuser,  // on_border
    output logic                  m_axis_tlast   // frame_last
);

    t_cfg                 cfg;
    t_pos_info            pos_info;
    logic [ADDR_W-1:0]    pos_col;
    logic                 accept;
    logic                 s1_adv;
    logic                 out_free;
    logic [2*COLOR_W-1:0] rd_data;
    logic [COLOR_W-1:0]   above2;
    logic [COLOR_W-1:0]   above1;
    logic [COLOR_W-1:0]   in_color;
    logic [COLOR_W-1:0]   res_color;

    // stage one registers
    logic                 r_s1_valid;
    t_pos_info            r_s1_info;
    logic [COLOR_W-1:0]   r_s1_color;
    logic [ADDR_W-1:0]    r_s1_col;
    logic                 r_fwd;
    logic [2*COLOR_W-1:0] r_fwd_data;

    assign o_cfg_ready = 1'b1;

    sobth_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake
    assign s1_adv        = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sobth_pos_ctrl u_pos_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (cfg),
        .o_col    (pos_col),
        .o_info   (pos_info)
    );

    // internal color packing: red high, blue low; flush enters as black
    assign in_color = s_axis_tuser ? '0 :
                      {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    // line stores, corrected by the write still in flight at read time
    assign above2 = r_fwd ? r_fwd_data[2*COLOR_W-1:COLOR_W] : rd_data[2*COLOR_W-1:COLOR_W];
    assign above1 = r_fwd ? r_fwd_data[COLOR_W-1:0]         : rd_data[COLOR_W-1:0];

    sobth_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (pos_col),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({above1, r_s1_color})
    );

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= s1_adv && (r_s1_col == pos_col);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info  <= pos_info;
            r_s1_color <= in_color;
            r_s1_col   <= pos_col;
            r_fwd_data <= {above1, r_s1_color};
        end
    end

    sobth_grad_core u_grad_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_info      (r_s1_info),
        .i_color     (r_s1_color),
        .i_above2    (above2),
        .i_above1    (above1),
        .i_threshold (cfg.edge_threshold),
        .i_out_ready (m_axis_tready),
        .o_out_free  (out_free),
        .o_valid     (m_axis_tvalid),
        .o_color     (res_color),
        .o_border    (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    // result tdata: red in the low byte
    assign m_axis_tdata = {res_color[7:0], res_color[15:8], res_color[23:16]};

    // an empty stage one always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> s_axis_tready)
        else $error("input stalled with empty stage");

    // a held stage one blocks new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |-> !s_axis_tready)
        else $error("request taken while stage one is held");

    // an accepted request is held in stage one next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request not in stage one");

endmodule

// ----- src/sobth_cfg_regs.sv -----
// sobth_cfg_regs: configuration register file with clamped effective geometry
// depends on sobth_pkg
`timescale 1ns / 1ps

module sobth_cfg_regs import sobth_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [THR_W-1:0]    r_edge_threshold;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_edge_threshold <= RST_EDGE_THRESHOLD;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_FRAME_WIDTH:    r_frame_width    <= i_wr_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_wr_data[HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD: r_edge_threshold <= i_wr_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp geometry into the supported range
    always_comb begin
        if (r_frame_width < WIDTH_W'(MIN_DIM))
            o_cfg.frame_width = WIDTH_W'(MIN_DIM);
        else if (r_frame_width > WIDTH_W'(MAX_WIDTH))
            o_cfg.frame_width = WIDTH_W'(MAX_WIDTH);
        else
            o_cfg.frame_width = r_frame_width;

        if (r_frame_height < HEIGHT_W'(MIN_DIM))
            o_cfg.frame_height = HEIGHT_W'(MIN_DIM);
        else if (r_frame_height > HEIGHT_W'(MAX_HEIGHT))
            o_cfg.frame_height = HEIGHT_W'(MAX_HEIGHT);
        else
            o_cfg.frame_height = r_frame_height;

        o_cfg.edge_threshold = r_edge_threshold;
    end

endmodule

// ----- src/sobth_line_buf.sv -----
// sobth_line_buf: two line stores side by side, one read and one write port
// depends on sobth_pkg; contents are not cleared by reset
`timescale 1ns / 1ps

module sobth_line_buf import sobth_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [2*COLOR_W-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [2*COLOR_W-1:0] i_wr_data
);

    // upper line in the high half, middle line in the low half
    logic [2*COLOR_W-1:0] r_mem [MAX_WIDTH];
    logic [2*COLOR_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/sobth_pos_ctrl.sv -----
// sobth_pos_ctrl: raster position counters and border / last / result flags
// depends on sobth_pkg
`timescale 1ns / 1ps

module sobth_pos_ctrl import sobth_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_cfg              i_cfg,
    output logic [ADDR_W-1:0] o_col,
    output t_pos_info         o_info
);

    logic [ADDR_W-1:0]   r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [ADDR_W-1:0]   n_col;
    logic [HEIGHT_W-1:0] n_row;
    logic [HEIGHT_W-1:0] q_row;
    logic [WIDTH_W-1:0]  q_col;
    logic [WIDTH_W-1:0]  col_inc;
    logic                col_nz;

    assign col_nz  = (r_col != '0);
    assign col_inc = {1'b0, r_col} + WIDTH_W'(1);

    // flags for the pixel whose result this request releases
    always_comb begin
        o_info.has_result = (r_row >= HEIGHT_W'(2)) || (r_row == HEIGHT_W'(1) && col_nz);
        o_info.last = ({1'b0, r_row} >= ({1'b0, i_cfg.frame_height} + (HEIGHT_W+1)'(1)))
                      && !col_nz;
        if (col_nz) begin
            q_row = r_row - HEIGHT_W'(1);
            q_col = {1'b0, r_col} - WIDTH_W'(1);
        end else begin
            q_row = r_row - HEIGHT_W'(2);
            q_col = i_cfg.frame_width - WIDTH_W'(1);
        end
        o_info.border = (q_row == '0) || (q_row == i_cfg.frame_height - HEIGHT_W'(1)) ||
                        (q_col == '0) || (q_col == i_cfg.frame_width - WIDTH_W'(1));
    end

    // next position
    always_comb begin
        if (o_info.has_result && o_info.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= i_cfg.frame_width) begin
            n_col = '0;
            n_row = r_row + HEIGHT_W'(1);
        end else begin
            n_col = col_inc[ADDR_W-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;

    // a frame-closing request restarts the raster
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_info.has_result && o_info.last |=> r_row == '0 && r_col == '0)
        else $error("position not reset after last pixel");

    // no result before the second line has started
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row == '0 |-> !o_info.has_result)
        else $error("result flagged on the first line");

endmodule

// ----- src/sobth_grad_core.sv -----
// sobth_grad_core: red window, sobel magnitude, threshold and the result register
// depends on sobth_pkg
`timescale 1ns / 1ps

module sobth_grad_core import sobth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_pos_info          i_info,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [COLOR_W-1:0] i_above2,
    input  logic [COLOR_W-1:0] i_above1,
    input  logic [THR_W-1:0]   i_threshold,
    input  logic               i_out_ready,
    output logic               o_out_free,
    output logic               o_valid,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_border,
    output logic               o_last
);

    logic [PIX_W-1:0]   r_win [9];
    logic [COLOR_W-1:0] r_center;
    logic [PIX_W-1:0]   n_win [9];

    logic               r_valid;
    logic [COLOR_W-1:0] r_color;
    logic               r_border;
    logic               r_last;

    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic [9:0]         gx_mag, gy_mag;
    logic [PIX_W:0]     total;
    logic [COLOR_W-1:0] n_color;

    // window after shifting in the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = i_above2[COLOR_W-1 -: PIX_W];
        n_win[5] = i_above1[COLOR_W-1 -: PIX_W];
        n_win[8] = i_color[COLOR_W-1 -: PIX_W];
    end

    // gradient magnitudes over red, each divided by nine
    always_comb begin
        gx_pos = 10'(n_win[2]) + {1'b0, n_win[5], 1'b0} + 10'(n_win[8]);
        gx_neg = 10'(n_win[0]) + {1'b0, n_win[3], 1'b0} + 10'(n_win[6]);
        gy_pos = 10'(n_win[6]) + {1'b0, n_win[7], 1'b0} + 10'(n_win[8]);
        gy_neg = 10'(n_win[0]) + {1'b0, n_win[1], 1'b0} + 10'(n_win[2]);
        gx_mag = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_mag = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        total  = {1'b0, div9(gx_mag)} + {1'b0, div9(gy_mag)};
        if (i_info.border)
            n_color = r_center;
        else if (total > {1'b0, i_threshold})
            n_color = COLOR_EDGE;
        else
            n_color = COLOR_NO_EDGE;
    end

    // window and center update once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
            r_center <= '0;
        end else if (i_adv) begin
            for (int k = 0; k < 9; k++) r_win[k] <= n_win[k];
            r_center <= i_above1;
        end
    end

    assign o_out_free = !r_valid || i_out_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv && i_info.has_result) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_info.has_result) begin
            r_color  <= n_color;
            r_border <= i_info.border;
            r_last   <= i_info.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_color  = r_color;
    assign o_border = r_border;
    assign o_last   = r_last;

    // interior results are pure black or pure white
    a_interior_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_border |-> (r_color == COLOR_EDGE || r_color == COLOR_NO_EDGE))
        else $error("interior result is not black or white");

    // a released result is always presented next cycle
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_info.has_result |=> r_valid)
        else $error("result lost on load");

endmodule
